// ----- design/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants of the max-first priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] element;
        logic signed [15:0] prio;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] removed_element;
        logic signed [15:0] removed_prio;
        logic               is_full_flag;
        logic               is_empty_flag;
    } t_result;

    typedef struct packed {
        logic signed [31:0] element;
        logic signed [15:0] prio;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_shift_ctl;

endpackage

// ----- design/max_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// max_priority_queue_unit
// Bounded priority queue, highest priority first, oldest first among equals.
//
//   channel   signals                              direction
//   request   i_start, o_busy, i_req               in
//   result    o_done, o_result                     out
//   config    i_cfg_valid, o_cfg_ready, i_cfg_data in
//
// One request per cycle; its result appears with o_done in the cycle after.
// Entries sit sorted in a chain of DEPTH cells; every cell compares the new
// priority in the same cycle, so an enqueue or dequeue is one chain shift.
// Synchronous active-low reset empties the queue and sets capacity to 64.
// Results are not held: o_done lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module max_priority_queue_unit #(
    parameter int DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  mpq_pkg::t_request      i_req,
    output logic                   o_done,
    output mpq_pkg::t_result       o_result,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [mpq_pkg::CAP_W-1:0] i_cfg_data
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int XW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_result          r_result;
    t_result          n_result;

    logic [XW-1:0]    cap_eff;
    logic [XW-1:0]    count_x;
    logic [XW-1:0]    n_count_x;
    logic             accept;
    logic             enq_ok;
    logic             deq_ok;
    t_shift_ctl       ctl;
    t_entry           new_entry;
    t_entry           w_entry [DEPTH];
    logic             w_ins   [DEPTH];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = XW'(1);
        end else if (XW'(r_capacity) > XW'(DEPTH)) begin
            cap_eff = XW'(DEPTH);
        end else begin
            cap_eff = XW'(r_capacity);
        end
    end

    assign count_x   = XW'(r_count);
    assign enq_ok    = accept && (i_req.req_type == REQ_ENQ) && (count_x < cap_eff);
    assign deq_ok    = accept && (i_req.req_type == REQ_DEQ) && (r_count != '0);
    assign ctl.enq   = enq_ok;
    assign ctl.deq   = deq_ok;
    assign new_entry = '{element: i_req.element, prio: i_req.prio};

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            t_entry left_entry;
            t_entry right_entry;
            logic   left_ins;
            if (g == 0) begin : g_head
                assign left_entry = '0;
                assign left_ins   = 1'b0;
            end else begin : g_mid
                assign left_entry = w_entry[g-1];
                assign left_ins   = w_ins[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_entry = '0;
            end else begin : g_body
                assign right_entry = w_entry[g+1];
            end
            mpq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_valid       (CNT_W'(g) < r_count),
                .i_new         (new_entry),
                .i_left_entry  (left_entry),
                .i_left_ins    (left_ins),
                .i_right_entry (right_entry),
                .o_entry       (w_entry[g]),
                .o_ins         (w_ins[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (enq_ok) begin
            n_count = r_count + 1'b1;
        end else if (deq_ok) begin
            n_count = r_count - 1'b1;
        end
        n_count_x = XW'(n_count);

        n_result                 = '0;
        n_result.status          = ST_DONE;
        if (i_req.req_type == REQ_ENQ) begin
            if (!enq_ok) begin
                n_result.status = ST_FULL;
            end
        end else begin
            if (deq_ok) begin
                n_result.removed_element = w_entry[0].element;
                n_result.removed_prio    = w_entry[0].prio;
            end else begin
                n_result.status = ST_EMPTY;
            end
        end
        n_result.is_full_flag  = (n_count_x >= cap_eff);
        n_result.is_empty_flag = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_done_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("request without result");

    a_deq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq_ok |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not lower count");

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_DONE) |->
            (o_result.removed_element == '0 && o_result.removed_prio == '0))
        else $error("rejected request returned an entry");
`endif

endmodule

// ----- design/mpq_cell.sv -----
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds an entry, opens a gap for an insert
// and moves entries toward the head on a removal.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                i_clk,
    input  mpq_pkg::t_shift_ctl i_ctl,
    input  logic                i_valid,
    input  mpq_pkg::t_entry     i_new,
    input  mpq_pkg::t_entry     i_left_entry,
    input  logic                i_left_ins,
    input  mpq_pkg::t_entry     i_right_entry,
    output mpq_pkg::t_entry     o_entry,
    output logic                o_ins
);
    import mpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // strict compare keeps older entries of equal priority in front
    assign o_ins   = !i_valid || (i_new.prio > r_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (i_left_ins) begin
                n_entry = i_left_entry;
            end else if (o_ins) begin
                n_entry = i_new;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- bench/mpq_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_scoreboard_pkg
// Scoreboard of the priority queue bench: keeps its own copy of the queued
// entries and the capacity, works out the result of every accepted request
// and compares each returned result with the oldest one still awaited.
// ----------------------------------------------------------------------------
package mpq_scoreboard_pkg;

    import mpq_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int SHOWN_MISMATCHES = 10;

    class mpq_scoreboard;

        t_entry           held[$];
        t_result          expected_results[$];
        logic [CAP_W-1:0] capacity;
        int               n_requests;
        int               n_results;
        int               n_mismatches;
        int               n_removed;
        int               n_refused_full;
        int               n_refused_empty;
        int               n_cap_writes;

        function new();
            capacity = CAP_RESET;
        endfunction

        // capacity 0 acts as 1, anything past the store depth as the depth
        function int usable_capacity();
            if (capacity == 0) return 1;
            if (capacity > STORE_DEPTH) return STORE_DEPTH;
            return int'(capacity);
        endfunction

        function void note_capacity(logic [CAP_W-1:0] value);
            capacity = value;
            n_cap_writes++;
        endfunction

        function void note_request(t_request r);
            t_result res;
            t_entry  slot;
            int      best;
            int      lim;
            res = '0;
            res.status = ST_DONE;
            lim = usable_capacity();
            if (r.req_type == REQ_ENQ) begin
                if (held.size() >= lim) begin
                    res.status = ST_FULL;
                    n_refused_full++;
                end else begin
                    slot.element = r.element;
                    slot.prio = r.prio;
                    held.push_back(slot);
                end
            end else if (held.size() == 0) begin
                res.status = ST_EMPTY;
                n_refused_empty++;
            end else begin
                // strict compare keeps the oldest among equal priorities
                best = 0;
                for (int i = 1; i < held.size(); i++) begin
                    if (held[i].prio > held[best].prio) best = i;
                end
                res.removed_element = held[best].element;
                res.removed_prio = held[best].prio;
                held.delete(best);
                n_removed++;
            end
            res.is_full_flag = (held.size() >= lim);
            res.is_empty_flag = (held.size() == 0);
            expected_results.push_back(res);
            n_requests++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (expected_results.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= SHOWN_MISMATCHES) begin
                    $display("result with no request outstanding: status %0d element %0d prio %0d",
                             got.status, got.removed_element, got.removed_prio);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.removed_element !== want.removed_element ||
                got.removed_prio !== want.removed_prio ||
                got.is_full_flag !== want.is_full_flag ||
                got.is_empty_flag !== want.is_empty_flag) begin
                n_mismatches++;
                if (n_mismatches <= SHOWN_MISMATCHES) begin
                    $display("mismatch on result %0d (expected/actual):", n_results);
                    $display("  status %0d/%0d element %0d/%0d prio %0d/%0d full %b/%b empty %b/%b",
                             want.status, got.status, want.removed_element, got.removed_element,
                             want.removed_prio, got.removed_prio, want.is_full_flag,
                             got.is_full_flag, want.is_empty_flag, got.is_empty_flag);
                end
            end
        endfunction

    endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench of the max-first priority queue. A directed part covers the empty
// and full refusals, priority extremes and ties; random phases then sweep
// the capacity (out of range and lowered below the fill level) with
// enqueue-heavy and dequeue-heavy traffic and random request gaps.
// ----------------------------------------------------------------------------
module tb_top;

    import mpq_pkg::*;
    import mpq_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES = 7;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_request         i_req;
    logic             o_done;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    mpq_scoreboard sb;
    int            idle_pct;
    int            cycle_count = 0;

    max_priority_queue_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_request(i_req);
            if (i_cfg_valid && o_cfg_ready) sb.note_capacity(i_cfg_data);
            if (o_done) sb.check_result(o_result);
        end
    end

    function automatic t_request make_request(logic kind, logic signed [31:0] elem,
                                              logic signed [15:0] pr);
        t_request r;
        r.req_type = kind;
        r.element = elem;
        r.prio = pr;
        return r;
    endfunction

    // a narrow band as often as the full range, so ties are common, plus extremes
    function automatic logic signed [15:0] pick_prio();
        logic signed [15:0] p;
        p = 16'($urandom);
        case ($urandom_range(9))
            0: p = 16'sh7fff;
            1: p = 16'sh8000;
            2, 3, 4, 5: begin
                p = 16'($urandom_range(6));
                p = p - 16'sd3;
            end
            default: ;
        endcase
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_request(input t_request r);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_req = r;
        do begin
            @(posedge i_clk);
            taken = !o_busy;
        end while (!taken);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_start = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        logic taken;
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do begin
            @(posedge i_clk);
            taken = o_cfg_ready;
        end while (!taken);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int count, input int enq_pct);
        t_request r;
        for (int i = 0; i < count; i++) begin
            r.req_type = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
            r.element = $urandom;
            r.prio = pick_prio();
            issue_request(r);
        end
    endtask

    initial begin
        int phase_cap[NUM_PHASES]   = '{127, 2, 64, 1, 5, 64, 0};
        int phase_idle[NUM_PHASES]  = '{0, 47, 32, 0, 47, 0, 32};
        int phase_enq[NUM_PHASES]   = '{75, 30, 55, 50, 55, 85, 40};
        int phase_count[NUM_PHASES] = '{150, 110, 140, 60, 80, 100, 60};

        sb = new();
        idle_pct = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty refusal, extremes and oldest-first among equal priorities
        issue_request(make_request(REQ_DEQ, 32'sd7, 16'sd7));
        issue_request(make_request(REQ_ENQ, 32'sh7fffffff, 16'sh8000));
        issue_request(make_request(REQ_ENQ, 32'sh80000000, 16'sh7fff));
        issue_request(make_request(REQ_ENQ, 32'sd1, 16'sd5));
        issue_request(make_request(REQ_ENQ, 32'sd2, 16'sd5));
        issue_request(make_request(REQ_ENQ, -32'sd1, -16'sd1));
        issue_request(make_request(REQ_ENQ, 32'sd0, 16'sd0));
        repeat (7) issue_request(make_request(REQ_DEQ, 32'shffffffff, 16'shffff));
        wait_drained();

        // capacity zero behaves as one
        write_capacity(7'd0);
        issue_request(make_request(REQ_ENQ, 32'sh55aa55aa, 16'sd100));
        issue_request(make_request(REQ_ENQ, 32'sh2a55aa55, 16'sd200));
        issue_request(make_request(REQ_DEQ, 32'sd0, 16'sd0));
        issue_request(make_request(REQ_DEQ, 32'sd0, 16'sd0));
        wait_drained();

        // phases mix fill and drain traffic; the second lowers capacity below the count
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(ph == NUM_PHASES - 1 ? CAP_W'($urandom_range(3, 127))
                                                 : CAP_W'(phase_cap[ph]));
            idle_pct = phase_idle[ph];
            run_phase(phase_count[ph], phase_enq[ph]);
            wait_drained();
        end

        $display("covered %0d requests over %0d capacity settings: %0d dequeued, %0d refused full,",
                 sb.n_requests, sb.n_cap_writes + 1, sb.n_removed, sb.n_refused_full);
        $display("%0d refused empty, %0d results checked, %0d mismatches, %0d left outstanding",
                 sb.n_refused_empty, sb.n_results, sb.n_mismatches, sb.expected_results.size());
        if (sb.n_mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
